// ===== src/lcdfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfb_pkg
// Shared types and constants of the monochrome LCD frame buffer renderer.
// ----------------------------------------------------------------------------
package lcdfb_pkg;

   // default geometry: 16 column bytes by 64 rows (128x64 pixels)
   localparam int COLUMN_BYTES_DEF = 16;
   localparam int ROWS_DEF         = 64;

   // controller address instruction mark and the lower screen half mapping
   localparam logic [7:0] ADDR_MARK       = 8'h80;
   localparam logic [6:0] HALF_ROWS       = 7'd32;
   localparam logic [7:0] HALF_COL_OFFSET = 8'd8;

   // pixel mask for bit index 0, the leftmost pixel
   localparam logic [7:0] PIXEL_MSB = 8'h80;

   typedef enum logic [2:0] {
      CMD_SET          = 3'd0,
      CMD_CLEAR        = 3'd1,
      CMD_TOGGLE       = 3'd2,
      CMD_WRITE        = 3'd3,
      CMD_CLEAR_REGION = 3'd4,
      CMD_RENDER       = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MODIFY,
      ST_ADDR_V,
      ST_ADDR_H,
      ST_DATA
   } state_type;

   typedef struct packed {
      logic       strobe;
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_type;

endpackage

// ===== src/lcdfb_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfb_mem
// Frame store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lcdfb_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lcdfb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfb_ctrl
// Command sequencer: pixel read-modify-write, byte write, region sweep and
// row render over the frame store.
// ----------------------------------------------------------------------------
module lcdfb_ctrl #(
   parameter int COLUMN_BYTES = lcdfb_pkg::COLUMN_BYTES_DEF,
   parameter int ROWS         = lcdfb_pkg::ROWS_DEF,
   parameter int ADDR_W       = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_command,
   input  logic [3:0]          req_x_byte,
   input  logic [2:0]          req_bit_index,
   input  logic [5:0]          req_y,
   input  logic [4:0]          req_x_end,
   input  logic [6:0]          req_y_end,
   input  logic [7:0]          req_value,
   output logic                mem_wr_en,
   output logic [ADDR_W-1:0]   mem_wr_addr,
   output logic [7:0]          mem_wr_data,
   output logic                mem_rd_en,
   output logic [ADDR_W-1:0]   mem_rd_addr,
   input  logic [7:0]          mem_rd_data,
   output lcdfb_pkg::rsp_type  rsp
);

   localparam logic [4:0] COLS_W = 5'(COLUMN_BYTES);
   localparam logic [6:0] ROWS_W = 7'(ROWS);

   function automatic logic [ADDR_W-1:0] addr_of(logic [4:0] x, logic [6:0] y);
      return ADDR_W'(32'(y) * COLUMN_BYTES + 32'(x));
   endfunction

   lcdfb_pkg::state_type state_ff, state_in;
   lcdfb_pkg::cmd_type   op_ff, op_in, cmd;
   logic [4:0] x_ff, x_in, x_first_ff, x_first_in, x_stop_ff, x_stop_in;
   logic [6:0] y_ff, y_in, y_stop_ff, y_stop_in;
   logic [7:0] mask_ff, mask_in;
   logic [4:0] x_end_clip, x_next;
   logic [6:0] y_end_clip, y_next, y_req, v_addr;
   logic       in_range, upper_half;

   assign cmd        = lcdfb_pkg::cmd_type'(req_command);
   assign y_req      = {1'b0, req_y};
   assign in_range   = ({1'b0, req_x_byte} < COLS_W) && (y_req < ROWS_W);
   assign x_end_clip = (req_x_end > COLS_W) ? COLS_W : req_x_end;
   assign y_end_clip = (req_y_end > ROWS_W) ? ROWS_W : req_y_end;
   assign x_next     = x_ff + 5'd1;
   assign y_next     = y_ff + 7'd1;
   assign upper_half = (y_ff >= lcdfb_pkg::HALF_ROWS);
   assign v_addr     = upper_half ? (y_ff - lcdfb_pkg::HALF_ROWS) : y_ff;
   assign busy       = (state_ff != lcdfb_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         // sweep the whole store to zero after reset
         state_ff   <= lcdfb_pkg::ST_SWEEP;
         x_ff       <= '0;
         y_ff       <= '0;
         x_first_ff <= '0;
         x_stop_ff  <= COLS_W;
         y_stop_ff  <= ROWS_W;
      end else begin
         state_ff   <= state_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         x_first_ff <= x_first_in;
         x_stop_ff  <= x_stop_in;
         y_stop_ff  <= y_stop_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      mask_ff <= mask_in;
   end

   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      x_first_in  = x_first_ff;
      x_stop_in   = x_stop_ff;
      y_stop_in   = y_stop_ff;
      op_in       = op_ff;
      mask_in     = mask_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_of(x_ff, y_ff);
      mem_wr_data = 8'd0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = addr_of(x_ff, y_ff);
      rsp         = '0;

      unique case (state_ff)
         lcdfb_pkg::ST_IDLE: begin
            if (start) begin
               unique case (cmd) inside
                  lcdfb_pkg::CMD_SET, lcdfb_pkg::CMD_CLEAR, lcdfb_pkg::CMD_TOGGLE: begin
                     if (in_range) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = addr_of({1'b0, req_x_byte}, y_req);
                        x_in        = {1'b0, req_x_byte};
                        y_in        = y_req;
                        op_in       = cmd;
                        mask_in     = lcdfb_pkg::PIXEL_MSB >> req_bit_index;
                        state_in    = lcdfb_pkg::ST_MODIFY;
                     end
                  end
                  lcdfb_pkg::CMD_WRITE: begin
                     if (in_range) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = addr_of({1'b0, req_x_byte}, y_req);
                        mem_wr_data = req_value;
                     end
                  end
                  lcdfb_pkg::CMD_CLEAR_REGION: begin
                     if (({1'b0, req_x_byte} < x_end_clip) && (y_req < y_end_clip)) begin
                        x_in       = {1'b0, req_x_byte};
                        x_first_in = {1'b0, req_x_byte};
                        x_stop_in  = x_end_clip;
                        y_in       = y_req;
                        y_stop_in  = y_end_clip;
                        state_in   = lcdfb_pkg::ST_SWEEP;
                     end
                  end
                  lcdfb_pkg::CMD_RENDER: begin
                     if (y_req < ROWS_W) begin
                        // force the start column even
                        x_in      = {1'b0, req_x_byte[3:1], 1'b0};
                        x_stop_in = x_end_clip;
                        y_in      = y_req;
                        state_in  = lcdfb_pkg::ST_ADDR_V;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         lcdfb_pkg::ST_MODIFY: begin
            mem_wr_en = 1'b1;
            unique case (op_ff)
               lcdfb_pkg::CMD_SET:   mem_wr_data = mem_rd_data | mask_ff;
               lcdfb_pkg::CMD_CLEAR: mem_wr_data = mem_rd_data & ~mask_ff;
               default:              mem_wr_data = mem_rd_data ^ mask_ff;
            endcase
            state_in = lcdfb_pkg::ST_IDLE;
         end
         lcdfb_pkg::ST_SWEEP: begin
            mem_wr_en = 1'b1;
            if (x_next == x_stop_ff) begin
               x_in = x_first_ff;
               y_in = y_next;
               if (y_next == y_stop_ff) begin
                  state_in = lcdfb_pkg::ST_IDLE;
               end
            end else begin
               x_in = x_next;
            end
         end
         lcdfb_pkg::ST_ADDR_V: begin
            rsp.strobe   = 1'b1;
            rsp.bus_byte = lcdfb_pkg::ADDR_MARK | {1'b0, v_addr};
            state_in     = lcdfb_pkg::ST_ADDR_H;
         end
         lcdfb_pkg::ST_ADDR_H: begin
            rsp.strobe   = 1'b1;
            rsp.bus_byte = lcdfb_pkg::ADDR_MARK | ({4'd0, x_ff[4:1]}
                           + (upper_half ? lcdfb_pkg::HALF_COL_OFFSET : 8'd0));
            rsp.last     = (x_ff >= x_stop_ff);
            if (x_ff >= x_stop_ff) begin
               state_in = lcdfb_pkg::ST_IDLE;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = lcdfb_pkg::ST_DATA;
            end
         end
         lcdfb_pkg::ST_DATA: begin
            rsp.strobe   = 1'b1;
            rsp.is_data  = 1'b1;
            rsp.bus_byte = mem_rd_data;
            rsp.last     = (x_next == x_stop_ff);
            if (x_next == x_stop_ff) begin
               state_in = lcdfb_pkg::ST_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = addr_of(x_next, y_ff);
               x_in        = x_next;
            end
         end
         default: begin
            state_in = lcdfb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/mono_lcd_framebuffer_render_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_lcd_framebuffer_render_top
// Monochrome graphic LCD frame buffer with pixel/byte/region edits and a row
// renderer that emits controller address instructions and data bytes.
// ----------------------------------------------------------------------------
//
//  channel   ports                         transaction completes when
//  --------  ----------------------------  ------------------------------
//  command   start, busy, req_*            start high and busy low
//  result    rsp_strobe, rsp_*             rsp_strobe high (one cycle)
//
// What each command does once accepted:
//   write byte stores the byte; set/clear/toggle pixel reads, then modifies and writes
//   back over the single frame store port pair; clear region clears one byte a
//   cycle; render row emits address instructions, then data bytes (one store read a byte).
// Reset is synchronous; after it the store is swept to zero one byte a cycle,
//   with busy high.
// Results cannot be stalled: each one sits on rsp_* for exactly the cycle
//   that rsp_strobe marks.
// ----------------------------------------------------------------------------
module mono_lcd_framebuffer_render_top #(
   parameter int COLUMN_BYTES = lcdfb_pkg::COLUMN_BYTES_DEF,
   parameter int ROWS         = lcdfb_pkg::ROWS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_command,
   input  logic [3:0] req_x_byte,
   input  logic [2:0] req_bit_index,
   input  logic [5:0] req_y,
   input  logic [4:0] req_x_end,
   input  logic [6:0] req_y_end,
   input  logic [7:0] req_value,
   output logic       rsp_strobe,
   output logic       rsp_is_data,
   output logic [7:0] rsp_bus_byte,
   output logic       rsp_last
);

   localparam int DEPTH  = COLUMN_BYTES * ROWS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic              mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [7:0]        mem_wr_data, mem_rd_data;
   lcdfb_pkg::rsp_type rsp;

   // sequencer: owns all command decoding and the result strobe
   lcdfb_ctrl #(
      .COLUMN_BYTES (COLUMN_BYTES),
      .ROWS         (ROWS),
      .ADDR_W       (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_x_byte    (req_x_byte),
      .req_bit_index (req_bit_index),
      .req_y         (req_y),
      .req_x_end     (req_x_end),
      .req_y_end     (req_y_end),
      .req_value     (req_value),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data),
      .rsp           (rsp)
   );

   // frame store, row-major: address = row * COLUMN_BYTES + column
   lcdfb_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // drive the result ports straight from the sequencer
   assign rsp_strobe   = rsp.strobe;
   assign rsp_is_data  = rsp.is_data;
   assign rsp_bus_byte = rsp.bus_byte;
   assign rsp_last     = rsp.last;

endmodule

// ===== src/lcdfb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdfb_checker
// Port-level checks of the frame buffer renderer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdfb_checker #(
   parameter int ROWS = lcdfb_pkg::ROWS_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_command,
   input logic [5:0] req_y,
   input logic       rsp_strobe,
   input logic       rsp_is_data,
   input logic       rsp_last
);

   // reset always starts the clearing sweep
   a_reset_sweep: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result while idle");

   // an accepted in-range render opens with an address instruction
   a_render_open: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == lcdfb_pkg::CMD_RENDER)
       && ({1'b0, req_y} < 7'(ROWS)))
      |=> (rsp_strobe && !rsp_is_data))
      else $error("render did not open with an address byte");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("result right after end of run");

   a_data_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_data) |-> $past(rsp_strobe))
      else $error("data byte without preceding result");

endmodule

bind mono_lcd_framebuffer_render_top lcdfb_checker #(.ROWS(ROWS)) u_checker (.*);
